/* design/bpcr_pkg.sv */
// ---------------------------------------------------------------------------
// bpcr_pkg
// Shared types and constants of the bus pin capture ring.
// ---------------------------------------------------------------------------
`default_nettype none

package bpcr_pkg;

   localparam int PIN_W = 40;

   localparam logic [2:0] OPC_CAPTURE = 3'd0;
   localparam logic [2:0] OPC_DRAIN   = 3'd1;
   localparam logic [2:0] OPC_POP     = 3'd2;
   localparam logic [2:0] OPC_TICK    = 3'd3;
   localparam logic [2:0] OPC_FLUSH   = 3'd4;

   localparam int PIN_ADDR_LO = 8;
   localparam int PIN_ADDR_HI = 21;
   localparam int PIN_DATA    = 25;
   localparam int PIN_PHI2    = 36;
   localparam int PIN_SYNC    = 6;
   localparam int PIN_RW      = 33;
   localparam int PIN_VP      = 0;
   localparam int PIN_ML      = 4;
   localparam int PIN_IRQ     = 3;
   localparam int PIN_NMI     = 5;
   localparam int PIN_RES     = 39;

   localparam int FLAG_PHI2 = 0;
   localparam int FLAG_SYNC = 1;
   localparam int FLAG_RES  = 7;

   localparam logic       CSR_MAX_BACKLOG   = 1'b0;
   localparam logic [7:0] MAX_BACKLOG_RESET = 8'd32;

   typedef enum logic [5:0] {
      CMD_CAPTURE = 6'b000001,
      CMD_DRAIN   = 6'b000010,
      CMD_POP     = 6'b000100,
      CMD_TICK    = 6'b001000,
      CMD_FLUSH   = 6'b010000,
      CMD_NOP     = 6'b100000
   } cmd_kind_type;

   typedef struct packed {
      logic [15:0] addr;
      logic [7:0]  data;
      logic [7:0]  flags;
   } sample_type;

   typedef struct packed {
      cmd_kind_type kind;
      sample_type   sample;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

`default_nettype wire

/* design/bpcr_req_if.sv */
// ---------------------------------------------------------------------------
// bpcr_req_if
// Request channel: opcode and pin snapshot with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface bpcr_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [39:0] pin_payload;

   modport source (output valid, output opcode, output pin_payload, input ready);
   modport sink (input valid, input opcode, input pin_payload, output ready);
endinterface

`default_nettype wire

/* design/bpcr_rsp_if.sv */
// ---------------------------------------------------------------------------
// bpcr_rsp_if
// Response channel: popped sample and monitor status with valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface bpcr_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] sample_addr;
   logic [7:0]  sample_data;
   logic [7:0]  sample_flags;
   logic        sample_valid;
   logic        ring_empty;
   logic [7:0]  backlog;
   logic        fast_skip;
   logic [31:0] phi2_cycles;
   logic [15:0] sync_addr;
   logic [7:0]  sync_opcode;
   logic        fetch_seen;
   logic [14:0] clock_rate;

   modport source (
      output valid, output sample_addr, output sample_data, output sample_flags,
      output sample_valid, output ring_empty, output backlog, output fast_skip,
      output phi2_cycles, output sync_addr, output sync_opcode, output fetch_seen,
      output clock_rate, input ready
   );
   modport sink (
      input valid, input sample_addr, input sample_data, input sample_flags,
      input sample_valid, input ring_empty, input backlog, input fast_skip,
      input phi2_cycles, input sync_addr, input sync_opcode, input fetch_seen,
      input clock_rate, output ready
   );
endinterface

`default_nettype wire

/* design/bpcr_ram.sv */
// ---------------------------------------------------------------------------
// bpcr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bpcr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* design/bpcr_front.sv */
// ---------------------------------------------------------------------------
// bpcr_front
// Accepts request transactions, decodes the opcode and unpacks the pins.
// ---------------------------------------------------------------------------
`default_nettype none

module bpcr_front (
   bpcr_req_if.sink          req,
   input  logic              full,
   output logic              push,
   output bpcr_pkg::cmd_type cmd
);
   import bpcr_pkg::*;

   function automatic sample_type unpack(logic [PIN_W-1:0] p);
      sample_type s;
      s.addr  = {p[PIN_ADDR_HI+3:PIN_ADDR_HI], p[PIN_ADDR_LO+11:PIN_ADDR_LO]};
      for (int i = 0; i < 8; i++) begin
         s.data[7-i] = p[PIN_DATA+i];
      end
      s.flags = {p[PIN_RES], p[PIN_NMI], p[PIN_IRQ], p[PIN_ML],
                 p[PIN_VP], p[PIN_RW], p[PIN_SYNC], p[PIN_PHI2]};
      return s;
   endfunction

   assign req.ready = !full;
   assign push      = req.valid && !full;

   always_comb begin
      cmd.sample = unpack(req.pin_payload);
      case (req.opcode)
         OPC_CAPTURE: cmd.kind = CMD_CAPTURE;
         OPC_DRAIN:   cmd.kind = CMD_DRAIN;
         OPC_POP:     cmd.kind = CMD_POP;
         OPC_TICK:    cmd.kind = CMD_TICK;
         OPC_FLUSH:   cmd.kind = CMD_FLUSH;
         default:     cmd.kind = CMD_NOP;
      endcase
   end

endmodule

`default_nettype wire

/* design/bpcr_queue.sv */
// ---------------------------------------------------------------------------
// bpcr_queue
// Two-entry command queue between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module bpcr_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  bpcr_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output bpcr_pkg::cmd_type          head,
   output bpcr_pkg::queue_status_type status
);
   import bpcr_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_idx_ff, wr_idx_in;
   logic       rd_idx_ff, rd_idx_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;

   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);
   assign do_push      = push && !status.full;
   assign head         = entry_ff[rd_idx_ff];

   always_comb begin
      wr_idx_in = do_push ? !wr_idx_ff : wr_idx_ff;
      rd_idx_in = pop ? !rd_idx_ff : rd_idx_ff;
      count_in  = count_ff;
      if (do_push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_idx_ff] <= push_cmd;
      end
      if (reset) begin
         wr_idx_ff <= 1'b0;
         rd_idx_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* design/bpcr_back.sv */
// ---------------------------------------------------------------------------
// bpcr_back
// Executes commands against the sample ring and monitor state and holds
// the response transaction in an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module bpcr_back #(
   parameter int RING_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        max_backlog,
   input  bpcr_pkg::cmd_type cmd,
   input  logic              cmd_valid,
   output logic              cmd_take,
   bpcr_rsp_if.source        rsp
);
   import bpcr_pkg::*;

   localparam int PW = $clog2(RING_DEPTH);
   localparam int CW = (PW > 8) ? PW : 8;
   localparam logic [PW-1:0] LAST    = PW'(RING_DEPTH - 1);
   localparam logic [PW:0]   DEPTH_X = (PW+1)'(RING_DEPTH);

   typedef struct packed {
      logic        ring_empty;
      logic [7:0]  backlog;
      logic        fast_skip;
      logic [31:0] phi2_cycles;
      logic [15:0] sync_addr;
      logic [7:0]  sync_opcode;
      logic        fetch_seen;
      logic [14:0] clock_rate;
   } status_type;

   function automatic logic [PW-1:0] ring_add(logic [PW-1:0] p, logic [PW-1:0] n);
      logic [PW:0] s;
      s = {1'b0, p} + {1'b0, n};
      if (s >= DEPTH_X) begin
         s = s - DEPTH_X;
      end
      return s[PW-1:0];
   endfunction

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0] held_ff, held_in;
   logic          prev_phi2_ff, prev_phi2_in;
   logic [31:0]   cycle_ff, cycle_in;
   logic [15:0]   sync_addr_ff, sync_addr_in;
   logic [7:0]    sync_opcode_ff, sync_opcode_in;
   logic          fetch_seen_ff, fetch_seen_in;
   logic [15:0]   hcc_ff, hcc_in;
   logic [14:0]   rate_ff, rate_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          pop_valid_ff, pop_valid_in;
   status_type    status_ff, status_in;

   logic          fire, ram_we, ram_re, skip;
   logic          phi2, sync, res;
   logic [CW-1:0] held_cw, max_cw, held_next_cw;
   logic [31:0]   ram_rdata;
   sample_type    rd_sample;

   assign fire     = cmd_valid && (!rsp_valid_ff || rsp.ready);
   assign cmd_take = fire;
   assign held_cw  = CW'(held_ff);
   assign max_cw   = CW'(max_backlog);
   assign phi2     = cmd.sample.flags[FLAG_PHI2];
   assign sync     = cmd.sample.flags[FLAG_SYNC];
   assign res      = cmd.sample.flags[FLAG_RES];

   always_comb begin
      wr_ptr_in      = wr_ptr_ff;
      rd_ptr_in      = rd_ptr_ff;
      held_in        = held_ff;
      prev_phi2_in   = prev_phi2_ff;
      cycle_in       = cycle_ff;
      sync_addr_in   = sync_addr_ff;
      sync_opcode_in = sync_opcode_ff;
      fetch_seen_in  = fetch_seen_ff;
      hcc_in         = hcc_ff;
      rate_in        = rate_ff;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      skip           = 1'b0;
      pop_valid_in   = 1'b0;
      if (fire) begin
         case (cmd.kind)
            CMD_CAPTURE: begin
               ram_we    = 1'b1;
               wr_ptr_in = ring_add(wr_ptr_ff, PW'(1));
               if (held_ff != LAST) begin
                  held_in = held_ff + PW'(1);
               end else begin
                  rd_ptr_in = ring_add(rd_ptr_ff, PW'(1));
               end
               if (phi2 && !prev_phi2_ff) begin
                  cycle_in = cycle_ff + 32'd1;
               end
               if (!res) begin
                  cycle_in = 32'd0;
               end
               prev_phi2_in = phi2;
               if (phi2 && sync) begin
                  sync_addr_in   = cmd.sample.addr;
                  sync_opcode_in = cmd.sample.data;
                  fetch_seen_in  = 1'b1;
               end
               hcc_in = hcc_ff + 16'd1;
            end
            CMD_DRAIN: begin
               if (held_cw > max_cw) begin
                  rd_ptr_in = ring_add(rd_ptr_ff, PW'(held_cw - max_cw));
                  held_in   = PW'(max_cw);
                  skip      = 1'b1;
               end
            end
            CMD_POP: begin
               if (held_ff != '0) begin
                  ram_re       = 1'b1;
                  rd_ptr_in    = ring_add(rd_ptr_ff, PW'(1));
                  held_in      = held_ff - PW'(1);
                  pop_valid_in = 1'b1;
               end
            end
            CMD_TICK: begin
               rate_in = hcc_ff[15:1];
               hcc_in  = 16'd0;
            end
            CMD_FLUSH: begin
               rd_ptr_in = wr_ptr_ff;
               held_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      held_next_cw          = CW'(held_in);
      status_in.ring_empty  = (held_in == '0);
      status_in.backlog     = (held_next_cw > CW'(255)) ? 8'hFF : held_next_cw[7:0];
      status_in.fast_skip   = skip;
      status_in.phi2_cycles = cycle_in;
      status_in.sync_addr   = sync_addr_in;
      status_in.sync_opcode = sync_opcode_in;
      status_in.fetch_seen  = fetch_seen_in;
      status_in.clock_rate  = rate_in;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   bpcr_ram #(
      .WIDTH (32),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_ptr_ff),
      .wdata (cmd.sample),
      .re    (ram_re),
      .raddr (rd_ptr_ff),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff <= status_in;
      end
      if (reset) begin
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         held_ff        <= '0;
         prev_phi2_ff   <= 1'b0;
         cycle_ff       <= 32'd0;
         sync_addr_ff   <= 16'd0;
         sync_opcode_ff <= 8'd0;
         fetch_seen_ff  <= 1'b0;
         hcc_ff         <= 16'd0;
         rate_ff        <= 15'd0;
         rsp_valid_ff   <= 1'b0;
         pop_valid_ff   <= 1'b0;
      end else begin
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         held_ff        <= held_in;
         prev_phi2_ff   <= prev_phi2_in;
         cycle_ff       <= cycle_in;
         sync_addr_ff   <= sync_addr_in;
         sync_opcode_ff <= sync_opcode_in;
         fetch_seen_ff  <= fetch_seen_in;
         hcc_ff         <= hcc_in;
         rate_ff        <= rate_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (fire) begin
            pop_valid_ff <= pop_valid_in;
         end
      end
   end

   assign rd_sample        = ram_rdata;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.sample_addr  = pop_valid_ff ? rd_sample.addr : 16'd0;
   assign rsp.sample_data  = pop_valid_ff ? rd_sample.data : 8'd0;
   assign rsp.sample_flags = pop_valid_ff ? rd_sample.flags : 8'd0;
   assign rsp.sample_valid = pop_valid_ff;
   assign rsp.ring_empty   = status_ff.ring_empty;
   assign rsp.backlog      = status_ff.backlog;
   assign rsp.fast_skip    = status_ff.fast_skip;
   assign rsp.phi2_cycles  = status_ff.phi2_cycles;
   assign rsp.sync_addr    = status_ff.sync_addr;
   assign rsp.sync_opcode  = status_ff.sync_opcode;
   assign rsp.fetch_seen   = status_ff.fetch_seen;
   assign rsp.clock_rate   = status_ff.clock_rate;

endmodule

`default_nettype wire

/* design/bus_pin_capture_ring.sv */
// ---------------------------------------------------------------------------
// bus_pin_capture_ring
// CPU bus monitor: captures 40-pin snapshots into a sample ring and keeps
// cycle, opcode fetch and clock rate status.
//
// req carries one opcode and pin snapshot per transaction; rsp returns one
// status transaction per request, in order, holding the popped sample when
// the request was a pop. max_backlog is written over the csr APB port at
// byte address 0 and reads back there.
// A request accepted into the queue gets its response from the response
// register. Throughput: one transaction per clock while rsp is ready; the
// front decodes into a two-entry queue and the back executes one command
// per clock when not stalled, reading the ring RAM's registered read port.
// Reset clears the ring to empty, all counters and the fetch latch, and
// sets max_backlog to 32. The ring contents need no clearing pass.
// While rsp is stalled the response register holds, the back stops and the
// queue fills; req.ready drops once both queue entries are occupied.
// ---------------------------------------------------------------------------
`default_nettype none

module bus_pin_capture_ring #(
   parameter int RING_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   bpcr_req_if.sink    req,
   bpcr_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bpcr_pkg::*;

   cmd_type          front_cmd, q_head;
   logic             front_push, q_pop;
   queue_status_type q_status;
   logic [7:0]       max_backlog_ff;
   logic             csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_MAX_BACKLOG) ? {24'd0, max_backlog_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_backlog_ff <= MAX_BACKLOG_RESET;
      end else if (csr_write && csr_paddr[2] == CSR_MAX_BACKLOG) begin
         max_backlog_ff <= csr_pwdata[7:0];
      end
   end

   bpcr_front u_front (
      .req  (req),
      .full (q_status.full),
      .push (front_push),
      .cmd  (front_cmd)
   );

   bpcr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_cmd (front_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .status   (q_status)
   );

   bpcr_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .max_backlog (max_backlog_ff),
      .cmd         (q_head),
      .cmd_valid   (!q_status.empty),
      .cmd_take    (q_pop),
      .rsp         (rsp)
   );

   a_idle_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("response valid straight after reset");

   a_empty_means_zero : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ring_empty |-> rsp.backlog == 8'd0)
      else $error("empty ring reports a backlog");

   a_drain_keeps_limit : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.fast_skip |-> rsp.backlog == max_backlog_ff)
      else $error("drain left a backlog other than the limit");

   a_latency : assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && q_status.empty && !rsp.valid |-> ##2 rsp.valid)
      else $error("response missing two cycles after an idle request");

endmodule

`default_nettype wire
